// ===== hw/rtl/bcts_pkg.sv =====
package bcts_pkg;

    localparam int NUM_FIELDS  = 7;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [2:0] field_idx_t;
    typedef logic [7:0] bcd_t;

    localparam field_idx_t F_SECONDS = 3'd0;
    localparam field_idx_t F_MINUTES = 3'd1;
    localparam field_idx_t F_HOURS   = 3'd2;
    localparam field_idx_t F_WEEKDAY = 3'd3;
    localparam field_idx_t F_DATE    = 3'd4;
    localparam field_idx_t F_MONTH   = 3'd5;
    localparam field_idx_t F_YEAR    = 3'd6;

    localparam bcd_t CEIL_SECMIN  = 8'h59;
    localparam bcd_t CEIL_HOURS   = 8'h23;
    localparam bcd_t CEIL_WEEKDAY = 8'h07;
    localparam bcd_t CEIL_DATE    = 8'h31;
    localparam bcd_t CEIL_MONTH   = 8'h12;
    localparam bcd_t CEIL_YEAR    = 8'h99;
    localparam bcd_t FLOOR_ONE    = 8'h01;
    localparam bcd_t FLOOR_ZERO   = 8'h00;

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_ENTER = 3'd1,
        OP_DEC   = 3'd2,
        OP_INC   = 3'd3,
        OP_PREV  = 3'd4,
        OP_NEXT  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        KIND_NOP   = 3'd0,
        KIND_LOAD  = 3'd1,
        KIND_ENTER = 3'd2,
        KIND_DEC   = 3'd3,
        KIND_INC   = 3'd4,
        KIND_PREV  = 3'd5,
        KIND_NEXT  = 3'd6
    } kind_t;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] load_index;
        logic [7:0] load_value;
    } in_word_t;

    typedef struct packed {
        logic [2:0] selected_field;
        logic [2:0] selector_digit;
        logic [3:0] high_digit;
        logic [3:0] low_digit;
        logic       commit;
        logic [7:0] seconds_bcd;
        logic [7:0] minutes_bcd;
        logic [7:0] hours_bcd;
        logic [7:0] weekday_bcd;
        logic [7:0] date_bcd;
        logic [7:0] month_bcd;
        logic [7:0] year_bcd;
    } out_word_t;

    typedef struct packed {
        kind_t      kind;
        field_idx_t load_index;
        bcd_t       load_value;
    } cmd_t;

    function automatic bcd_t bcd_up(bcd_t v);
        logic [3:0] hi;
        logic [3:0] lo;
        hi = v[7:4];
        lo = v[3:0];
        if (lo >= 4'd9)
        begin
            return {hi + 4'd1, 4'd0};
        end
        return {hi, lo + 4'd1};
    endfunction

    function automatic bcd_t bcd_down(bcd_t v);
        logic [3:0] hi;
        logic [3:0] lo;
        hi = v[7:4];
        lo = v[3:0];
        if (lo == 4'd0)
        begin
            return {hi - 4'd1, 4'd9};
        end
        return {hi, lo - 4'd1};
    endfunction

    function automatic bcd_t floor_of(field_idx_t f);
        if (f == F_WEEKDAY || f == F_DATE || f == F_MONTH)
        begin
            return FLOOR_ONE;
        end
        return FLOOR_ZERO;
    endfunction

    function automatic bcd_t ceiling_of(field_idx_t f);
        bcd_t c;
        case (f)
            F_YEAR:    c = CEIL_YEAR;
            F_MONTH:   c = CEIL_MONTH;
            F_DATE:    c = CEIL_DATE;
            F_WEEKDAY: c = CEIL_WEEKDAY;
            F_HOURS:   c = CEIL_HOURS;
            default:   c = CEIL_SECMIN;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/bcts_front.sv =====
module bcts_front (
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  bcts_pkg::in_word_t cmd,
    input  logic              q_full,
    output logic              q_push,
    output bcts_pkg::cmd_t    q_cmd
);
    import bcts_pkg::*;

    assign cmd_stall = q_full;
    assign q_push    = cmd_valid && !q_full;

    always_comb
    begin
        q_cmd.load_index = cmd.load_index;
        q_cmd.load_value = cmd.load_value;
        case (cmd.op)
            OP_LOAD:
            begin
                // a load past the year field writes nothing
                if (cmd.load_index > F_YEAR)
                begin
                    q_cmd.kind = KIND_NOP;
                end
                else
                begin
                    q_cmd.kind = KIND_LOAD;
                end
            end
            OP_ENTER: q_cmd.kind = KIND_ENTER;
            OP_DEC:   q_cmd.kind = KIND_DEC;
            OP_INC:   q_cmd.kind = KIND_INC;
            OP_PREV:  q_cmd.kind = KIND_PREV;
            OP_NEXT:  q_cmd.kind = KIND_NEXT;
            default:  q_cmd.kind = KIND_NOP;
        endcase
    end

endmodule

// ===== hw/rtl/bcts_queue.sv =====
module bcts_queue #(
    parameter int DEPTH = bcts_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bcts_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output bcts_pkg::cmd_t head_cmd
);
    import bcts_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count over depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/bcts_back.sv =====
module bcts_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  bcts_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output bcts_pkg::out_word_t result
);
    import bcts_pkg::*;

    bcd_t       fields_reg [NUM_FIELDS];
    bcd_t       fields_next [NUM_FIELDS];
    field_idx_t index_reg;
    field_idx_t index_next;
    bcd_t       sel_value_reg;
    bcd_t       sel_value_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_word_t  out_reg;
    out_word_t  out_next;
    logic       fire;
    logic       commit_c;

    assign fire         = q_not_empty && (!out_valid_reg || !result_stall);
    assign q_pop        = fire;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        fields_next = fields_reg;
        index_next  = index_reg;
        commit_c    = 1'b0;
        case (q_cmd.kind)
            KIND_LOAD:  fields_next[q_cmd.load_index] = q_cmd.load_value;
            KIND_ENTER: index_next = F_YEAR;
            KIND_DEC:
            begin
                if (sel_value_reg > floor_of(index_reg))
                begin
                    fields_next[index_reg] = bcd_down(sel_value_reg);
                end
            end
            KIND_INC:
            begin
                if (sel_value_reg < ceiling_of(index_reg))
                begin
                    fields_next[index_reg] = bcd_up(sel_value_reg);
                end
            end
            KIND_PREV:
            begin
                if (index_reg > F_SECONDS)
                begin
                    index_next = index_reg - 3'd1;
                end
                else
                begin
                    commit_c = 1'b1;
                end
            end
            KIND_NEXT:
            begin
                if (index_reg < F_YEAR)
                begin
                    index_next = index_reg + 3'd1;
                end
            end
            default: ;
        endcase

        sel_value_next = fields_next[index_next];

        out_next.selected_field = index_next;
        out_next.selector_digit = 3'd7 - index_next;
        out_next.low_digit      = sel_value_next[3:0];
        case (index_next)
            F_MONTH:   out_next.high_digit = {3'b000, sel_value_next[4]};
            F_WEEKDAY: out_next.high_digit = 4'd0;
            F_HOURS:   out_next.high_digit = {2'b00, sel_value_next[5:4]};
            default:   out_next.high_digit = sel_value_next[7:4];
        endcase
        out_next.commit      = commit_c;
        out_next.seconds_bcd = fields_next[F_SECONDS];
        out_next.minutes_bcd = fields_next[F_MINUTES];
        out_next.hours_bcd   = fields_next[F_HOURS];
        out_next.weekday_bcd = fields_next[F_WEEKDAY];
        out_next.date_bcd    = fields_next[F_DATE];
        out_next.month_bcd   = fields_next[F_MONTH];
        out_next.year_bcd    = fields_next[F_YEAR];

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                fields_reg[i] <= '0;
            end
            index_reg     <= F_YEAR;
            sel_value_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                fields_reg    <= fields_next;
                index_reg     <= index_next;
                sel_value_reg <= sel_value_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

`ifndef ASSERT_OFF
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= F_YEAR)
        else $error("field index out of range");
    a_commit_at_seconds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.commit) |-> (out_reg.selected_field == F_SECONDS))
        else $error("commit away from seconds");
    a_sel_value_coherent: assert property (@(posedge clk) disable iff (!rst_n)
        sel_value_reg == fields_reg[index_reg])
        else $error("selected value out of step with fields");
    a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("executed word not presented");
`endif

endmodule

// ===== hw/rtl/bcd_clock_time_setter.sv =====
// bcd clock time setter: edits seven packed-bcd time fields from button words
// cmd channel: cmd_valid / cmd_stall carry one word of op, load_index, load_value
// result channel: result_valid / result_stall carry one word per cmd word, with the
//   selected field, selector digit, masked display digits, commit flag and all fields
// a taken cmd word is registered in the queue and then in the output register before
//   it shows as a result
// throughput: one word per cycle unless stalled, set by the bcd step in the back end
// the front end classifies ops into a small queue; the back end executes them
//   against the field registers and holds the result in an output register
// a stalled result holds; the queue keeps taking words until it fills, so up to
//   queue depth plus one words are in flight before cmd_stall rises
// reset clears all fields to zero, selects the year field and empties the queue
module bcd_clock_time_setter #(
    parameter int QUEUE_DEPTH = bcts_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  bcts_pkg::in_word_t  cmd,
    output logic                result_valid,
    input  logic                result_stall,
    output bcts_pkg::out_word_t result
);
    import bcts_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    bcts_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    bcts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    bcts_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_cmd        (head_cmd),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcts_pkg::*;

    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam field_idx_t NO_FIELD  = 3'd7;
    localparam int TOTAL_WORDS       = 1375;
    localparam int CALM_TAIL         = 200;
    localparam int HOLD_AFTER        = 400;
    localparam int HOLD_CYCLES       = 120;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    in_word_t  cmd = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_word_t result;

    bcd_t       time_regs [NUM_FIELDS];
    field_idx_t edit_field;
    bcd_t       field_ceiling [NUM_FIELDS] = '{CEIL_SECMIN, CEIL_SECMIN, CEIL_HOURS,
                                               CEIL_WEEKDAY, CEIL_DATE, CEIL_MONTH, CEIL_YEAR};
    bcd_t       field_floor [NUM_FIELDS] = '{FLOOR_ZERO, FLOOR_ZERO, FLOOR_ZERO,
                                             FLOOR_ONE, FLOOR_ONE, FLOOR_ONE, FLOOR_ZERO};

    in_word_t  button_words [$];
    out_word_t expected_words [$];
    out_word_t want_word;
    int        errors = 0;
    int        results_seen = 0;
    int        gap_left = 0;
    int        stall_left = 0;
    bit        held_once = 1'b0;

    bcd_clock_time_setter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // applies one button word to the local copy of the fields
    function automatic out_word_t apply_button(in_word_t w);
        field_idx_t f;
        bcd_t       v;
        logic       done;
        out_word_t  r;
        f = edit_field;
        done = 1'b0;
        case (w.op)
            OP_LOAD:
            begin
                if (w.load_index != NO_FIELD)
                begin
                    time_regs[w.load_index] = w.load_value;
                end
            end
            OP_ENTER: f = F_YEAR;
            OP_DEC:
            begin
                v = time_regs[f];
                if (v > field_floor[f])
                begin
                    time_regs[f] = (v[3:0] == 4'd0) ? {v[7:4] - 4'd1, 4'd9}
                                                    : {v[7:4], v[3:0] - 4'd1};
                end
            end
            OP_INC:
            begin
                v = time_regs[f];
                if (v < field_ceiling[f])
                begin
                    time_regs[f] = (v[3:0] >= 4'd9) ? {v[7:4] + 4'd1, 4'd0}
                                                    : {v[7:4], v[3:0] + 4'd1};
                end
            end
            OP_PREV:
            begin
                if (f == F_SECONDS)
                begin
                    done = 1'b1;
                end
                else
                begin
                    f = f - 3'd1;
                end
            end
            OP_NEXT:
            begin
                if (f != F_YEAR)
                begin
                    f = f + 3'd1;
                end
            end
            default: ;
        endcase
        edit_field = f;
        v = time_regs[f];
        r.selected_field = f;
        r.selector_digit = 3'd7 - f;
        r.low_digit = v[3:0];
        case (f)
            F_MONTH:   r.high_digit = {3'b000, v[4]};
            F_WEEKDAY: r.high_digit = 4'd0;
            F_HOURS:   r.high_digit = {2'b00, v[5:4]};
            default:   r.high_digit = v[7:4];
        endcase
        r.commit = done;
        r.seconds_bcd = time_regs[F_SECONDS];
        r.minutes_bcd = time_regs[F_MINUTES];
        r.hours_bcd = time_regs[F_HOURS];
        r.weekday_bcd = time_regs[F_WEEKDAY];
        r.date_bcd = time_regs[F_DATE];
        r.month_bcd = time_regs[F_MONTH];
        r.year_bcd = time_regs[F_YEAR];
        return r;
    endfunction

    function automatic bit idle_allowed();
        return button_words.size() >= CALM_TAIL && ((button_words.size() / 150) % 4) != 0;
    endfunction

    function automatic bcd_t pick_value(field_idx_t f);
        case ($urandom_range(0, 3))
            0: return field_ceiling[f];
            1: return field_floor[f];
            2: return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_word(logic [2:0] op, field_idx_t idx, bcd_t val);
        in_word_t w;
        w.op = op;
        w.load_index = idx;
        w.load_value = val;
        button_words.push_back(w);
    endtask

    // button press with don't-care index and value
    task automatic add_press(logic [2:0] op);
        add_word(op, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    // enter, walk from year down to seconds with loads and steps, then commit
    task automatic add_session();
        int f;
        int n;
        add_press(OP_ENTER);
        for (f = F_YEAR; f >= 0; f--)
        begin
            if ($urandom_range(0, 1) != 0)
            begin
                add_word(OP_LOAD, field_idx_t'(f), pick_value(field_idx_t'(f)));
            end
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                add_press(($urandom_range(0, 1) != 0) ? OP_INC : OP_DEC);
            end
            if (f != F_YEAR && $urandom_range(0, 7) == 0)
            begin
                add_press(OP_NEXT);
                add_press(OP_PREV);
            end
            add_press(OP_PREV);
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            gap_left <= 0;
        end
        else if (!cmd_valid || !cmd_stall)
        begin
            if (cmd_valid)
            begin
                expected_words.push_back(apply_button(cmd));
            end
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                cmd_valid <= 1'b0;
            end
            else if (idle_allowed() && $urandom_range(0, 9) == 0)
            begin
                gap_left <= $urandom_range(0, 16);
                cmd_valid <= 1'b0;
            end
            else if (button_words.size() != 0)
            begin
                cmd <= button_words.pop_front();
                cmd_valid <= 1'b1;
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
            held_once <= 1'b0;
        end
        else if (!held_once && results_seen >= HOLD_AFTER)
        begin
            // long hold so the block backs up into the command side
            held_once <= 1'b1;
            stall_left <= HOLD_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (idle_allowed() && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word 0x%0h", result));
            end
            else
            begin
                want_word = expected_words.pop_front();
                check_field("selected_field", result.selected_field, want_word.selected_field);
                check_field("selector_digit", result.selector_digit, want_word.selector_digit);
                check_field("high_digit", result.high_digit, want_word.high_digit);
                check_field("low_digit", result.low_digit, want_word.low_digit);
                check_field("commit", result.commit, want_word.commit);
                check_field("seconds_bcd", result.seconds_bcd, want_word.seconds_bcd);
                check_field("minutes_bcd", result.minutes_bcd, want_word.minutes_bcd);
                check_field("hours_bcd", result.hours_bcd, want_word.hours_bcd);
                check_field("weekday_bcd", result.weekday_bcd, want_word.weekday_bcd);
                check_field("date_bcd", result.date_bcd, want_word.date_bcd);
                check_field("month_bcd", result.month_bcd, want_word.month_bcd);
                check_field("year_bcd", result.year_bcd, want_word.year_bcd);
            end
        end
    end

    initial
    begin
        foreach (time_regs[i])
        begin
            time_regs[i] = '0;
        end
        edit_field = F_YEAR;

        // year at ceiling and non-bcd, then month at floor
        add_press(OP_ENTER);
        add_word(OP_LOAD, F_YEAR, 8'h99);
        add_press(OP_INC);
        add_word(OP_LOAD, F_YEAR, 8'hFF);
        add_press(OP_DEC);
        add_word(OP_LOAD, F_MONTH, 8'h01);
        add_press(OP_NEXT);
        add_press(OP_PREV);
        add_press(OP_DEC);
        add_press(OP_INC);
        // date borrow, weekday raw nibble, hours carry
        add_press(OP_PREV);
        add_word(OP_LOAD, F_DATE, 8'h10);
        add_press(OP_DEC);
        add_press(OP_PREV);
        add_word(OP_LOAD, F_WEEKDAY, 8'hAB);
        add_press(OP_INC);
        add_press(OP_PREV);
        add_word(OP_LOAD, F_HOURS, 8'h19);
        add_press(OP_INC);
        // down to seconds at floor, then commit
        add_press(OP_PREV);
        add_press(OP_PREV);
        add_press(OP_DEC);
        add_press(OP_PREV);
        // spare op codes and out-of-range load index
        add_word(OP_SPARE6, F_SECONDS, 8'h42);
        add_word(OP_SPARE7, NO_FIELD, 8'hFF);
        add_word(OP_LOAD, NO_FIELD, 8'h55);

        while (button_words.size() < TOTAL_WORDS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                add_session();
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    add_word(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                             8'($urandom_range(0, 255)));
                end
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (button_words.size() != 0 || cmd_valid || expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule
